/* hdl/tcch_pkg.sv */
// Shared constants, types and lookup tables of the compass heading engine.
package tcch_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int SAMPLE_BITS_DEF  = 21;

   localparam int OP_BITS    = 2;
   localparam int CENTI_BITS = 16;
   localparam int STEP_BITS  = 5;
   localparam int ATAN_LEN   = 24;
   localparam int ATAN_BITS  = 22;

   localparam int TRIG_BITS   = 16;
   localparam int COEF_BITS   = TRIG_BITS + 1;
   localparam int ROT_XY_BITS = 18;
   localparam int ROT_Z_BITS  = 25;
   localparam int VEC_Z_BITS  = 27;

   // centidegree to Q16 degree scaling: q = n*16384/25
   localparam int MAG_BITS    = 15;
   localparam int QUO_BITS    = 10;
   localparam int REM_BITS    = 5;
   localparam int FRAC_BITS   = 14;
   localparam int RECIP_BITS  = 16;
   localparam logic [RECIP_BITS-1:0] RECIP_25 = 16'd41944;
   localparam int RECIP_SHIFT = 20;
   localparam int DIV_25      = 25;

   localparam int CENTI_HALF  = 18000;
   localparam int CENTI_TURN  = 36000;
   localparam int ANG_90      = 90 * 65536;
   localparam int ANG_180     = 180 * 65536;
   localparam int CORDIC_GAIN = 19899;
   localparam int TRIG_MAX    = 32767;
   localparam int TRIG_MIN    = -32768;
   localparam int ROUND_BIAS  = 32768;
   localparam int Q16_SHIFT   = 16;
   localparam int Q15_SHIFT   = 15;
   localparam logic [CENTI_BITS-1:0] DECL_RESET = 16'd300;

   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR   = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_FINISH  = 2'd2,
      OP_HEADING = 2'd3
   } op_type;

   typedef struct packed {
      logic                 prep;
      logic                 scale;
      logic                 load;
      logic                 step;
      logic [STEP_BITS-1:0] idx;
   } rot_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
   } mac_ctrl_type;

   typedef struct packed {
      logic                 load;
      logic                 step;
      logic [STEP_BITS-1:0] idx;
   } vec_ctrl_type;

   typedef struct packed {
      logic clear;
      logic sample;
      logic finish;
   } cal_ctrl_type;

   // arctan(2^-i) in Q16 degrees
   function automatic logic [ATAN_BITS-1:0] atan_q16deg(input logic [STEP_BITS-1:0] idx);
      logic [ATAN_BITS-1:0] val;
      unique case (idx)
         5'd0:  val = 22'd2949120;
         5'd1:  val = 22'd1740967;
         5'd2:  val = 22'd919879;
         5'd3:  val = 22'd466945;
         5'd4:  val = 22'd234379;
         5'd5:  val = 22'd117304;
         5'd6:  val = 22'd58666;
         5'd7:  val = 22'd29335;
         5'd8:  val = 22'd14668;
         5'd9:  val = 22'd7334;
         5'd10: val = 22'd3667;
         5'd11: val = 22'd1833;
         5'd12: val = 22'd917;
         5'd13: val = 22'd458;
         5'd14: val = 22'd229;
         5'd15: val = 22'd115;
         5'd16: val = 22'd57;
         5'd17: val = 22'd29;
         5'd18: val = 22'd14;
         5'd19: val = 22'd7;
         5'd20: val = 22'd4;
         5'd21: val = 22'd2;
         5'd22: val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

   // floor(b * 16384 / 25) for a remainder b of 0..24
   function automatic logic [FRAC_BITS-1:0] frac25(input logic [REM_BITS-1:0] b);
      logic [FRAC_BITS-1:0] val;
      unique case (b)
         5'd0:  val = 14'd0;
         5'd1:  val = 14'd655;
         5'd2:  val = 14'd1310;
         5'd3:  val = 14'd1966;
         5'd4:  val = 14'd2621;
         5'd5:  val = 14'd3276;
         5'd6:  val = 14'd3932;
         5'd7:  val = 14'd4587;
         5'd8:  val = 14'd5242;
         5'd9:  val = 14'd5898;
         5'd10: val = 14'd6553;
         5'd11: val = 14'd7208;
         5'd12: val = 14'd7864;
         5'd13: val = 14'd8519;
         5'd14: val = 14'd9175;
         5'd15: val = 14'd9830;
         5'd16: val = 14'd10485;
         5'd17: val = 14'd11141;
         5'd18: val = 14'd11796;
         5'd19: val = 14'd12451;
         5'd20: val = 14'd13107;
         5'd21: val = 14'd13762;
         5'd22: val = 14'd14417;
         5'd23: val = 14'd15073;
         5'd24: val = 14'd15728;
         default: val = 14'd0;
      endcase
      return val;
   endfunction

endpackage

/* hdl/tcch_if.sv */
// Request and response channel interfaces of the compass heading engine.
interface tcch_req_if #(parameter int SAMPLE_BITS = tcch_pkg::SAMPLE_BITS_DEF);
   import tcch_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [OP_BITS-1:0]           operation;
   logic signed [SAMPLE_BITS-1:0] mag_x;
   logic signed [SAMPLE_BITS-1:0] mag_y;
   logic signed [SAMPLE_BITS-1:0] mag_z;
   logic signed [CENTI_BITS-1:0]  roll_centideg;
   logic signed [CENTI_BITS-1:0]  pitch_centideg;

   modport source (output valid, operation, mag_x, mag_y, mag_z, roll_centideg,
                   pitch_centideg, input ready);
   modport sink (input valid, operation, mag_x, mag_y, mag_z, roll_centideg,
                 pitch_centideg, output ready);
endinterface

interface tcch_rsp_if;
   import tcch_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CENTI_BITS-1:0] heading_centideg;
   logic                  heading_valid;

   modport source (output valid, heading_centideg, heading_valid, input ready);
   modport sink (input valid, heading_centideg, heading_valid, output ready);
endinterface

/* hdl/tcch_calib.sv */
// Hard-iron calibration: per-axis min/max trackers and doubled offsets.
module tcch_calib #(
   parameter int SAMPLE_BITS = tcch_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tcch_pkg::cal_ctrl_type        ctrl,
   input  logic signed [SAMPLE_BITS-1:0] mag_x,
   input  logic signed [SAMPLE_BITS-1:0] mag_y,
   input  logic signed [SAMPLE_BITS-1:0] mag_z,
   output logic signed [SAMPLE_BITS:0]   off_x,
   output logic signed [SAMPLE_BITS:0]   off_y,
   output logic signed [SAMPLE_BITS:0]   off_z
);
   import tcch_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] NEG_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] mag [3];
   logic signed [SAMPLE_BITS-1:0] min_ff [3];
   logic signed [SAMPLE_BITS-1:0] max_ff [3];
   logic signed [SAMPLE_BITS:0]   off_ff [3];
   logic                          seen_ff;

   assign mag[0] = mag_x;
   assign mag[1] = mag_y;
   assign mag[2] = mag_z;

   for (genvar k = 0; k < 3; k++) begin : g_axis
      always_ff @(posedge clock) begin
         if (reset || ctrl.clear) begin
            min_ff[k] <= POS_MAX;
            max_ff[k] <= NEG_MIN;
            off_ff[k] <= '0;
         end else begin
            if (ctrl.sample) begin
               if (mag[k] < min_ff[k]) min_ff[k] <= mag[k];
               if (mag[k] > max_ff[k]) max_ff[k] <= mag[k];
            end
            if (ctrl.finish) begin
               off_ff[k] <= seen_ff ? (SAMPLE_BITS+1)'(max_ff[k]) + (SAMPLE_BITS+1)'(min_ff[k])
                                    : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         seen_ff <= 1'b0;
      end else if (ctrl.sample) begin
         seen_ff <= 1'b1;
      end
   end

   assign off_x = off_ff[0];
   assign off_y = off_ff[1];
   assign off_z = off_ff[2];

endmodule

/* hdl/tcch_sincos.sv */
// Iterative CORDIC sine/cosine of a centidegree angle, one rotation step a cycle.
module tcch_sincos (
   input  logic                                  clock,
   input  tcch_pkg::rot_ctrl_type                ctrl,
   input  logic signed [tcch_pkg::CENTI_BITS-1:0] angle_centideg,
   output logic signed [tcch_pkg::TRIG_BITS-1:0]  sin_q15,
   output logic signed [tcch_pkg::TRIG_BITS-1:0]  cos_q15
);
   import tcch_pkg::*;

   logic signed [CENTI_BITS:0]    wide_r;
   logic signed [CENTI_BITS:0]    red_r;
   logic signed [CENTI_BITS:0]    abs_r;
   logic                          neg_ff;
   logic [MAG_BITS-1:0]           mag_ff;
   logic [QUO_BITS-1:0]           quo_ff;
   logic [MAG_BITS+RECIP_BITS-1:0] recip_prod;
   logic [MAG_BITS-1:0]           rem_full;
   logic [QUO_BITS+FRAC_BITS-1:0] q_abs;
   logic signed [ROT_Z_BITS-1:0]  z_start;
   logic signed [ROT_Z_BITS-1:0]  z_fold;
   logic                          flip;
   logic signed [ROT_XY_BITS-1:0] x_ff;
   logic signed [ROT_XY_BITS-1:0] y_ff;
   logic signed [ROT_Z_BITS-1:0]  z_ff;
   logic                          flip_ff;
   logic signed [ROT_Z_BITS-1:0]  ang_step;
   logic signed [ROT_XY_BITS:0]   cx;
   logic signed [ROT_XY_BITS:0]   cy;

   // reduce into [-180, 180) degrees and split into sign and magnitude
   always_comb begin
      wide_r = (CENTI_BITS+1)'(angle_centideg);
      if (wide_r >= CENTI_HALF) begin
         red_r = (CENTI_BITS+1)'(wide_r - CENTI_TURN);
      end else if (wide_r < -CENTI_HALF) begin
         red_r = (CENTI_BITS+1)'(wide_r + CENTI_TURN);
      end else begin
         red_r = wide_r;
      end
      abs_r = red_r[CENTI_BITS] ? -red_r : red_r;
   end

   assign recip_prod = MAG_BITS'(mag_ff) * RECIP_25;

   // q = floor(n/25)*16384 + floor((n mod 25)*16384/25), then fold into +-90 degrees
   always_comb begin
      rem_full = mag_ff - MAG_BITS'(32'(quo_ff) * DIV_25);
      q_abs    = {quo_ff, {FRAC_BITS{1'b0}}} + (QUO_BITS+FRAC_BITS)'(frac25(rem_full[REM_BITS-1:0]));
      z_start  = neg_ff ? -ROT_Z_BITS'(q_abs) : ROT_Z_BITS'(q_abs);
      flip     = 1'b0;
      z_fold   = z_start;
      if (z_start > ANG_90) begin
         z_fold = z_start - ROT_Z_BITS'(ANG_180);
         flip   = 1'b1;
      end else if (z_start < -ANG_90) begin
         z_fold = z_start + ROT_Z_BITS'(ANG_180);
         flip   = 1'b1;
      end
   end

   assign ang_step = ROT_Z_BITS'(atan_q16deg(ctrl.idx));

   always_ff @(posedge clock) begin
      if (ctrl.prep) begin
         neg_ff <= red_r[CENTI_BITS];
         mag_ff <= abs_r[MAG_BITS-1:0];
      end
      if (ctrl.scale) begin
         quo_ff <= recip_prod[RECIP_SHIFT +: QUO_BITS];
      end
      if (ctrl.load) begin
         x_ff    <= ROT_XY_BITS'(CORDIC_GAIN);
         y_ff    <= '0;
         z_ff    <= z_fold;
         flip_ff <= flip;
      end else if (ctrl.step) begin
         if (!z_ff[ROT_Z_BITS-1]) begin
            x_ff <= x_ff - (y_ff >>> ctrl.idx);
            y_ff <= y_ff + (x_ff >>> ctrl.idx);
            z_ff <= z_ff - ang_step;
         end else begin
            x_ff <= x_ff + (y_ff >>> ctrl.idx);
            y_ff <= y_ff - (x_ff >>> ctrl.idx);
            z_ff <= z_ff + ang_step;
         end
      end
   end

   // undo the fold and clamp to Q1.15
   always_comb begin
      cx = flip_ff ? -(ROT_XY_BITS+1)'(x_ff) : (ROT_XY_BITS+1)'(x_ff);
      cy = flip_ff ? -(ROT_XY_BITS+1)'(y_ff) : (ROT_XY_BITS+1)'(y_ff);
      if (cx > TRIG_MAX)      cos_q15 = TRIG_BITS'(TRIG_MAX);
      else if (cx < TRIG_MIN) cos_q15 = TRIG_BITS'(TRIG_MIN);
      else                    cos_q15 = cx[TRIG_BITS-1:0];
      if (cy > TRIG_MAX)      sin_q15 = TRIG_BITS'(TRIG_MAX);
      else if (cy < TRIG_MIN) sin_q15 = TRIG_BITS'(TRIG_MIN);
      else                    sin_q15 = cy[TRIG_BITS-1:0];
   end

endmodule

/* hdl/tcch_mac.sv */
// Bit-serial multiply-accumulate of the tilt compensation sums, MSB first.
module tcch_mac #(
   parameter int VB = tcch_pkg::SAMPLE_BITS_DEF + 3,
   parameter int AW = VB + tcch_pkg::COEF_BITS + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tcch_pkg::mac_ctrl_type               ctrl,
   input  logic signed [VB-1:0]                 v0,
   input  logic signed [VB-1:0]                 v1,
   input  logic signed [VB-1:0]                 v2,
   input  logic signed [tcch_pkg::COEF_BITS-1:0] cp,
   input  logic signed [tcch_pkg::COEF_BITS-1:0] srsp,
   input  logic signed [tcch_pkg::COEF_BITS-1:0] crsp,
   input  logic signed [tcch_pkg::COEF_BITS-1:0] cr,
   input  logic signed [tcch_pkg::COEF_BITS-1:0] sr,
   output logic signed [AW-1:0]                 xc,
   output logic signed [AW-1:0]                 yc
);
   import tcch_pkg::*;

   logic [COEF_BITS-1:0] sh_cp_ff, sh_srsp_ff, sh_crsp_ff, sh_cr_ff, sh_sr_ff;
   logic                 first_ff;
   logic signed [AW-1:0] acc_x_ff, acc_y_ff;
   logic signed [AW-1:0] term_x, term_y;

   // one coefficient bit of each product per cycle
   always_comb begin
      term_x = (sh_cp_ff[COEF_BITS-1]   ? AW'(v0) : AW'(0))
             + (sh_srsp_ff[COEF_BITS-1] ? AW'(v1) : AW'(0))
             + (sh_crsp_ff[COEF_BITS-1] ? AW'(v2) : AW'(0));
      term_y = (sh_cr_ff[COEF_BITS-1]   ? AW'(v1) : AW'(0))
             - (sh_sr_ff[COEF_BITS-1]   ? AW'(v2) : AW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
      end else if (ctrl.load) begin
         first_ff <= 1'b1;
      end else if (ctrl.step) begin
         first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         sh_cp_ff   <= cp;
         sh_srsp_ff <= srsp;
         sh_crsp_ff <= crsp;
         sh_cr_ff   <= cr;
         sh_sr_ff   <= sr;
         acc_x_ff   <= '0;
         acc_y_ff   <= '0;
      end else if (ctrl.step) begin
         sh_cp_ff   <= sh_cp_ff << 1;
         sh_srsp_ff <= sh_srsp_ff << 1;
         sh_crsp_ff <= sh_crsp_ff << 1;
         sh_cr_ff   <= sh_cr_ff << 1;
         sh_sr_ff   <= sh_sr_ff << 1;
         // sign bit carries negative weight
         acc_x_ff   <= first_ff ? -term_x : (acc_x_ff <<< 1) + term_x;
         acc_y_ff   <= first_ff ? -term_y : (acc_y_ff <<< 1) + term_y;
      end
   end

   assign xc = acc_x_ff;
   assign yc = acc_y_ff;

endmodule

/* hdl/tcch_atan.sv */
// Iterative CORDIC vectoring atan2 in Q16 degrees, one step a cycle.
module tcch_atan #(
   parameter int IW = tcch_pkg::SAMPLE_BITS_DEF + 21,
   parameter int CW = IW + 2
) (
   input  logic                                   clock,
   input  tcch_pkg::vec_ctrl_type                 ctrl,
   input  logic signed [IW-1:0]                   xc,
   input  logic signed [IW-1:0]                   yc,
   output logic signed [tcch_pkg::VEC_Z_BITS-1:0] angle_q16
);
   import tcch_pkg::*;

   logic signed [CW-1:0]         x_ff, y_ff;
   logic signed [VEC_Z_BITS-1:0] z_ff;
   logic                         zero_ff;
   logic signed [VEC_Z_BITS-1:0] ang_step;

   assign ang_step = VEC_Z_BITS'(atan_q16deg(ctrl.idx));

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         zero_ff <= (xc == '0) && (yc == '0);
         if (xc[IW-1]) begin
            // pre-rotate the left half plane by a half turn
            x_ff <= -CW'(xc);
            y_ff <= -CW'(yc);
            z_ff <= yc[IW-1] ? -VEC_Z_BITS'(ANG_180) : VEC_Z_BITS'(ANG_180);
         end else begin
            x_ff <= CW'(xc);
            y_ff <= CW'(yc);
            z_ff <= '0;
         end
      end else if (ctrl.step) begin
         if (!y_ff[CW-1]) begin
            x_ff <= x_ff + (y_ff >>> ctrl.idx);
            y_ff <= y_ff - (x_ff >>> ctrl.idx);
            z_ff <= z_ff + ang_step;
         end else begin
            x_ff <= x_ff - (y_ff >>> ctrl.idx);
            y_ff <= y_ff + (x_ff >>> ctrl.idx);
            z_ff <= z_ff - ang_step;
         end
      end
   end

   assign angle_q16 = zero_ff ? '0 : z_ff;

endmodule

/* hdl/tilt_compensated_compass_heading.sv */
// Top level of the tilt-compensated magnetometer compass heading engine.
//
//   channel  direction  handshake          payload
//   req_ch   in         valid / ready      operation, mag_x/y/z, roll/pitch_centideg
//   rsp_ch   out        valid / ready      heading_centideg, heading_valid
//   csr_     in         write enable only  declination_centideg
//
// Sequence: clear, sample and finish go from accept straight to the output state. A
// heading runs prepare, scale and load, then two S-step CORDIC passes (S =
// min(CORDIC_STEPS, 24); sine/cosine of roll and pitch in parallel, then atan2) with a
// bit-serial multiply-accumulate between them, then round and wrap.
// One word is in flight at a time; ready is high only in the idle state.
// Reset is synchronous: calibration goes to its empty state and declination to 3.00 deg.
// A result that is not taken stalls the engine in its output state; the
// output register holds the previous word meanwhile.
module tilt_compensated_compass_heading #(
   parameter int CORDIC_STEPS = tcch_pkg::CORDIC_STEPS_DEF,
   parameter int SAMPLE_BITS  = tcch_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tcch_req_if.sink                        req_ch,
   tcch_rsp_if.source                      rsp_ch,
   input  logic                            csr_write_en,
   input  logic [tcch_pkg::CENTI_BITS-1:0] csr_write_data
);
   import tcch_pkg::*;

   // calibrated axis width, compensation sum width, vectoring width
   localparam int VB = SAMPLE_BITS + 3;
   localparam int AW = VB + COEF_BITS + 1;
   localparam int CW = AW + 2;
   localparam int RUN_STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam logic [STEP_BITS-1:0] LAST_ROT = STEP_BITS'(RUN_STEPS - 1);
   localparam logic [STEP_BITS-1:0] LAST_MAC = STEP_BITS'(COEF_BITS - 1);
   localparam int RB = VEC_Z_BITS + 8;
   localparam int HB = CENTI_BITS + 2;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_PREP  = 12'b000000000010,
      S_SCALE = 12'b000000000100,
      S_LOAD  = 12'b000000001000,
      S_ROT   = 12'b000000010000,
      S_PROD  = 12'b000000100000,
      S_MAC   = 12'b000001000000,
      S_VLOAD = 12'b000010000000,
      S_VEC   = 12'b000100000000,
      S_ROUND = 12'b001000000000,
      S_WRAP  = 12'b010000000000,
      S_OUT   = 12'b100000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 accept;
   op_type               op;
   rot_ctrl_type         rot_ctrl;
   mac_ctrl_type         mac_ctrl;
   vec_ctrl_type         vec_ctrl;
   cal_ctrl_type         cal_ctrl;
   logic                 rsp_load;

   logic [CENTI_BITS-1:0]         decl_ff;
   logic signed [SAMPLE_BITS:0]   off_x, off_y, off_z;
   logic signed [VB-1:0]          v_ff [3];
   logic signed [CENTI_BITS-1:0]  roll_ff, pitch_ff;
   logic signed [TRIG_BITS-1:0]   sin_roll, cos_roll, sin_pitch, cos_pitch;
   logic signed [2*TRIG_BITS-1:0] srsp_full, crsp_full;
   logic signed [AW-1:0]          xc, yc;
   logic signed [VEC_Z_BITS-1:0]  angle_q16;
   logic signed [RB-1:0]          ang_wide, ang_scaled;
   logic signed [HB-1:0]          h_raw, h_ff, h_sum, h_wrap;
   logic [CENTI_BITS-1:0]         res_ff;
   logic                          res_valid_ff;
   logic                          rsp_valid_ff;
   logic [CENTI_BITS-1:0]         rsp_head_ff;
   logic                          rsp_hval_ff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign op           = op_type'(req_ch.operation);

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rot_ctrl = '0;
      mac_ctrl = '0;
      vec_ctrl = '0;
      rsp_load = 1'b0;
      rot_ctrl.idx = cnt_ff;
      vec_ctrl.idx = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = (op == OP_HEADING) ? S_PREP : S_OUT;
         end
         S_PREP: begin
            rot_ctrl.prep = 1'b1;
            state_in      = S_SCALE;
         end
         S_SCALE: begin
            rot_ctrl.scale = 1'b1;
            state_in       = S_LOAD;
         end
         S_LOAD: begin
            rot_ctrl.load = 1'b1;
            cnt_in        = '0;
            state_in      = S_ROT;
         end
         S_ROT: begin
            rot_ctrl.step = 1'b1;
            if (cnt_ff == LAST_ROT) begin
               state_in = S_PROD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_PROD: begin
            mac_ctrl.load = 1'b1;
            cnt_in        = '0;
            state_in      = S_MAC;
         end
         S_MAC: begin
            mac_ctrl.step = 1'b1;
            if (cnt_ff == LAST_MAC) begin
               state_in = S_VLOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_VLOAD: begin
            vec_ctrl.load = 1'b1;
            cnt_in        = '0;
            state_in      = S_VEC;
         end
         S_VEC: begin
            vec_ctrl.step = 1'b1;
            if (cnt_ff == LAST_ROT) begin
               state_in = S_ROUND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ROUND: state_in = S_WRAP;
         S_WRAP:  state_in = S_OUT;
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         decl_ff  <= DECL_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_write_en) decl_ff <= csr_write_data;
      end
   end

   // calibration updates take effect at accept
   always_comb begin
      cal_ctrl.clear  = accept && (op == OP_CLEAR);
      cal_ctrl.sample = accept && (op == OP_SAMPLE);
      cal_ctrl.finish = accept && (op == OP_FINISH);
   end

   tcch_calib #(.SAMPLE_BITS(SAMPLE_BITS)) u_calib (
      .clock (clock),
      .reset (reset),
      .ctrl  (cal_ctrl),
      .mag_x (req_ch.mag_x),
      .mag_y (req_ch.mag_y),
      .mag_z (req_ch.mag_z),
      .off_x (off_x),
      .off_y (off_y),
      .off_z (off_z)
   );

   // capture calibrated axes (doubled) and tilt at accept
   always_ff @(posedge clock) begin
      if (accept) begin
         v_ff[0]  <= (VB'(req_ch.mag_x) <<< 1) - VB'(off_x);
         v_ff[1]  <= (VB'(req_ch.mag_y) <<< 1) - VB'(off_y);
         v_ff[2]  <= (VB'(req_ch.mag_z) <<< 1) - VB'(off_z);
         roll_ff  <= req_ch.roll_centideg;
         pitch_ff <= req_ch.pitch_centideg;
      end
   end

   tcch_sincos u_sincos_roll (
      .clock          (clock),
      .ctrl           (rot_ctrl),
      .angle_centideg (roll_ff),
      .sin_q15        (sin_roll),
      .cos_q15        (cos_roll)
   );

   tcch_sincos u_sincos_pitch (
      .clock          (clock),
      .ctrl           (rot_ctrl),
      .angle_centideg (pitch_ff),
      .sin_q15        (sin_pitch),
      .cos_q15        (cos_pitch)
   );

   assign srsp_full = sin_roll * sin_pitch;
   assign crsp_full = cos_roll * sin_pitch;

   tcch_mac #(.VB(VB), .AW(AW)) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .v0    (v_ff[0]),
      .v1    (v_ff[1]),
      .v2    (v_ff[2]),
      .cp    (COEF_BITS'(cos_pitch)),
      .srsp  (COEF_BITS'(srsp_full >>> Q15_SHIFT)),
      .crsp  (COEF_BITS'(crsp_full >>> Q15_SHIFT)),
      .cr    (COEF_BITS'(cos_roll)),
      .sr    (COEF_BITS'(sin_roll)),
      .xc    (xc),
      .yc    (yc)
   );

   tcch_atan #(.IW(AW), .CW(CW)) u_atan (
      .clock     (clock),
      .ctrl      (vec_ctrl),
      .xc        (xc),
      .yc        (yc),
      .angle_q16 (angle_q16)
   );

   // Q16 degrees to centidegrees: floor((a*100 + 32768) / 65536)
   always_comb begin
      ang_wide   = RB'(angle_q16);
      ang_scaled = (ang_wide <<< 6) + (ang_wide <<< 5) + (ang_wide <<< 2) + RB'(ROUND_BIAS);
      h_raw      = HB'(ang_scaled >>> Q16_SHIFT);
      h_sum      = h_ff + HB'($signed(decl_ff));
      if (h_sum < 0) begin
         h_wrap = h_sum + HB'(CENTI_TURN);
      end else if (h_sum >= CENTI_TURN) begin
         h_wrap = h_sum - HB'(CENTI_TURN);
      end else begin
         h_wrap = h_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff       <= '0;
         res_valid_ff <= 1'b0;
      end
      if (state_ff == S_ROUND) begin
         h_ff <= h_raw[HB-1] ? h_raw + HB'(CENTI_TURN) : h_raw;
      end
      if (state_ff == S_WRAP) begin
         res_ff       <= h_wrap[CENTI_BITS-1:0];
         res_valid_ff <= 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_head_ff <= res_ff;
         rsp_hval_ff <= res_valid_ff;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.heading_centideg = rsp_head_ff;
   assign rsp_ch.heading_valid    = rsp_hval_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("second word accepted while one is in flight");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.heading_centideg < CENTI_TURN))
      else $error("heading out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.heading_valid) |-> (rsp_ch.heading_centideg == '0))
      else $error("non-heading word carries a heading");

endmodule
